@@ rtl/smn_pkg.sv @@
// ----------------------------------------------------------------------------
// smn_pkg: shared constants and types for the scaled median of point norms
// Widths, capacity, reciprocal for the divide by 100, sequencer states.
// ----------------------------------------------------------------------------
package smn_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 24;
    localparam int NORM_W     = 25;
    localparam int RAD_W      = 48;
    localparam int ROOT_W     = 24;
    localparam int MUL_W      = 27;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int BIT_W      = 5;
    localparam int STEP_W     = 5;
    localparam int SIGMA_W    = 19;
    localparam int USED_W     = 11;

    // floor(s / 100) == (s * RECIP) >> RECIP_SHIFT for every s below 2^30
    localparam logic [MUL_W-1:0] RECIP = 27'd85899346;
    localparam int RECIP_SHIFT = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_SEL_INIT,
        ST_SCAN,
        ST_BIT,
        ST_SCALE,
        ST_FIN
    } t_state;

endpackage

@@ rtl/smn_sqrt.sv @@
// ----------------------------------------------------------------------------
// smn_sqrt: iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle, floor of the root.
// ----------------------------------------------------------------------------
module smn_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [smn_pkg::RAD_W-1:0]    i_radicand,
    output logic                         o_done,
    output logic [smn_pkg::ROOT_W-1:0]   o_root
);
    import smn_pkg::*;

    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic [RAD_W-1:0]    r_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic                r_done;

    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic                take;

    assign rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(ROOT_W - 1);
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= take ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], take};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/scaled_median_of_point_norms.sv @@
// ----------------------------------------------------------------------------
// scaled_median_of_point_norms: 0.02 x median Euclidean norm of a point set
// Stores one norm per present point item while capacity lasts; on the last item selects the median by a
// bitwise radix search over the stored norms and scales it by 1/50.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | point_x/y/z, present, end
//  out     | output    | o_out_valid / i_out_ready  | sigma, points_used, overflow
//
//  A stored point passes through the multiplier steps, then the square-root steps.
//  The end of a set adds 25 radix passes over the n norms, twice for an even
//  count, then the scale step; one memory read port serves every pass.
//  Reset clears the count, the drop flag and the output valid; no memory clear.
//  The input is not ready while an item is in work; a pending result waits
//  in the output register and holds the final scale step.
// ----------------------------------------------------------------------------
module scaled_median_of_point_norms (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [smn_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [smn_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [smn_pkg::COORD_W-1:0] i_point_z,
    input  logic                          i_point_present,
    input  logic                          i_set_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [smn_pkg::SIGMA_W-1:0]   o_sigma_value,
    output logic [smn_pkg::USED_W-1:0]    o_points_used,
    output logic                          o_overflow_flag
);
    import smn_pkg::*;

    t_state r_state, n_state;

    logic [COORD_W-1:0] r_ax, r_ay, r_az;
    logic               r_end;
    logic [1:0]         r_idx;
    logic [RAD_W-1:0]   r_sum;
    logic [PROD_W-1:0]  r_prod;
    logic [CNT_W-1:0]   r_count;
    logic               r_dropped;

    logic [NORM_W-1:0]  mem [MAX_POINTS];
    logic [NORM_W-1:0]  r_rd_data;
    logic               r_rd_v;
    logic [CNT_W-1:0]   r_addr;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_k;
    logic [NORM_W-1:0]  r_prefix;
    logic [NORM_W-1:0]  r_va;
    logic [BIT_W-1:0]   r_bit;
    logic               r_pass;
    logic [NORM_W-1:0]  r_scale_in;

    logic               r_out_valid;
    logic [SIGMA_W-1:0] r_sigma;
    logic [USED_W-1:0]  r_used;
    logic               r_ovf;

    logic               accept;
    logic               sq_start;
    logic               sq_done;
    logic [ROOT_W-1:0]  sq_root;
    logic [RAD_W-1:0]   sum_final;
    logic [MUL_W-1:0]   mul_op_a, mul_op_b;
    logic               rd_en;
    logic               even;
    logic [NORM_W-1:0]  hi_mask;
    logic               match;
    logic [NORM_W-1:0]  new_prefix;
    logic               go_one;

    function automatic logic [COORD_W-1:0] abs_coord(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign accept    = i_in_valid && o_in_ready;
    assign sum_final = r_sum + r_prod[RAD_W-1:0];
    assign even      = ~r_count[0];
    assign hi_mask   = ~((NORM_W'(2) << r_bit) - 1'b1);
    assign match     = (((r_rd_data ^ r_prefix) & hi_mask) == '0) && !r_rd_data[r_bit];
    assign go_one    = !(r_k < r_cnt);
    assign new_prefix = go_one ? (r_prefix | (NORM_W'(1) << r_bit)) : r_prefix;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_point_present && (r_count < CNT_W'(MAX_POINTS)))
                        n_state = ST_MUL;
                    else if (i_set_end)
                        n_state = ST_SEL_INIT;
                end
            end
            ST_MUL:      if (r_idx == 2'd3) n_state = ST_SQRT;
            ST_SQRT:     if (sq_done) n_state = r_end ? ST_SEL_INIT : ST_IDLE;
            ST_SEL_INIT: n_state = (r_count == '0) ? ST_SCALE : ST_SCAN;
            ST_SCAN:     if ((r_addr == r_count) && !r_rd_v) n_state = ST_BIT;
            ST_BIT: begin
                if (r_bit != '0)       n_state = ST_SCAN;
                else if (even && !r_pass) n_state = ST_SCAN;
                else                   n_state = ST_SCALE;
            end
            ST_SCALE:    n_state = ST_FIN;
            ST_FIN:      if (!r_out_valid) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        sq_start   = (r_state == ST_MUL) && (r_idx == 2'd3);
        rd_en      = (r_state == ST_SCAN) && (r_addr != r_count);
        mul_op_a   = '0;
        mul_op_b   = '0;
        case (r_state)
            ST_MUL: begin
                case (r_idx)
                    2'd0:    mul_op_a = MUL_W'(r_ax);
                    2'd1:    mul_op_a = MUL_W'(r_ay);
                    default: mul_op_a = MUL_W'(r_az);
                endcase
                mul_op_b = mul_op_a;
            end
            // keep the scaled product steady while a result waits
            ST_SCALE, ST_FIN: begin
                mul_op_a = MUL_W'(r_scale_in);
                mul_op_b = RECIP;
            end
            default: ;
        endcase
    end

    smn_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sum_final),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_op_a * mul_op_b;
        if (rd_en)
            r_rd_data <= mem[r_addr[ADDR_W-1:0]];
        if ((r_state == ST_SQRT) && sq_done)
            mem[r_count[ADDR_W-1:0]] <= NORM_W'(sq_root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= rd_en;
            if (o_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_ax  <= abs_coord(i_point_x);
                        r_ay  <= abs_coord(i_point_y);
                        r_az  <= abs_coord(i_point_z);
                        r_end <= i_set_end;
                        r_idx <= 2'd0;
                        r_sum <= '0;
                        if (i_point_present && !(r_count < CNT_W'(MAX_POINTS)))
                            r_dropped <= 1'b1;
                    end
                end
                ST_MUL: begin
                    if (r_idx != 2'd0)
                        r_sum <= sum_final;
                    r_idx <= r_idx + 1'b1;
                end
                ST_SQRT: begin
                    if (sq_done)
                        r_count <= r_count + 1'b1;
                end
                ST_SEL_INIT: begin
                    r_k        <= even ? ((r_count >> 1) - 1'b1) : (r_count >> 1);
                    r_pass     <= 1'b0;
                    r_prefix   <= '0;
                    r_bit      <= BIT_W'(NORM_W - 1);
                    r_addr     <= '0;
                    r_cnt      <= '0;
                    r_scale_in <= '0;
                end
                ST_SCAN: begin
                    if (rd_en)
                        r_addr <= r_addr + 1'b1;
                    if (r_rd_v && match)
                        r_cnt <= r_cnt + 1'b1;
                end
                ST_BIT: begin
                    r_addr <= '0;
                    r_cnt  <= '0;
                    if (r_bit != '0) begin
                        if (go_one)
                            r_k <= r_k - r_cnt;
                        r_prefix <= new_prefix;
                        r_bit    <= r_bit - 1'b1;
                    end else if (even && !r_pass) begin
                        // lower middle found; search again for the upper one
                        r_va     <= new_prefix;
                        r_pass   <= 1'b1;
                        r_k      <= r_count >> 1;
                        r_prefix <= '0;
                        r_bit    <= BIT_W'(NORM_W - 1);
                    end else begin
                        r_scale_in <= even ? (r_va + new_prefix) : (new_prefix << 1);
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_sigma     <= r_prod[RECIP_SHIFT +: SIGMA_W];
                        r_used      <= USED_W'(r_count);
                        r_ovf       <= r_dropped;
                        r_count     <= '0;
                        r_dropped   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sigma_value   = r_sigma;
    assign o_points_used   = r_used;
    assign o_overflow_flag = r_ovf;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");
    a_sqrt_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_SQRT))
        else $error("root finished outside the root step");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside the final step");
    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_rd_v)
        else $error("memory read pending while accepting");
`endif

endmodule
